### hdl/bfpd_pkg.sv
package bfpd_pkg;

    // operand size and fraction scaling
    localparam int DIGITS = 32;
    localparam int FRAC   = 8;

    // derived sizes
    localparam int DW   = 4;
    localparam int WIN  = DIGITS + 1;
    localparam int NPOS = DIGITS + FRAC;
    localparam int LPW  = $clog2(DIGITS);
    localparam int CW   = $clog2(WIN);
    localparam int PW   = $clog2(NPOS + 1);

    typedef logic [DW-1:0] t_digit;

    localparam t_digit ZERO_DIGIT = 4'd0;
    localparam t_digit BCD_MAX    = 4'd9;
    localparam t_digit RADIX      = 4'd10;

    typedef logic [DIGITS-1:0][DW-1:0] t_qvec;
    typedef logic [WIN-1:0][DW-1:0]    t_wvec;

    // flags that travel with one quotient
    typedef struct packed {
        logic positive;
        logic div_zero;
        logic overflow;
    } t_flags;

    // non-bcd codes saturate at nine
    function automatic t_digit clamp_bcd(input t_digit d);
        return (d > BCD_MAX) ? BCD_MAX : d;
    endfunction

endpackage

### hdl/bfpd_digit_sub.sv
module bfpd_digit_sub (
    input  logic                i_clk,
    input  logic                i_clear,
    input  logic                i_step,
    input  bfpd_pkg::t_digit    i_minuend,
    input  bfpd_pkg::t_digit    i_subtrahend,
    output bfpd_pkg::t_digit    o_diff,
    output logic                o_borrow
);
    import bfpd_pkg::*;

    logic       r_borrow;
    logic       n_borrow;
    logic [4:0] s_raw;

    // one bcd digit of minuend - subtrahend - borrow
    always_comb begin
        s_raw    = {1'b0, i_minuend} - {1'b0, i_subtrahend} - {4'b0, r_borrow};
        n_borrow = s_raw[4];
        o_diff   = s_raw[4] ? (s_raw[3:0] + RADIX) : s_raw[3:0];
    end

    // borrow carried from one digit to the next
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_borrow <= 1'b0;
        end else if (i_step) begin
            r_borrow <= n_borrow;
        end
    end

    assign o_borrow = r_borrow;

endmodule

### hdl/bfpd_core.sv
module bfpd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bfpd_pkg::t_digit    i_dividend_digit,
    input  bfpd_pkg::t_digit    i_divisor_digit,
    input  logic                i_dividend_positive,
    input  logic                i_divisor_positive,
    input  logic                i_last_digit,
    output logic                o_res_valid,
    input  logic                i_res_take,
    output bfpd_pkg::t_qvec     o_quotient,
    output bfpd_pkg::t_flags    o_flags
);
    import bfpd_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SHIFT,
        S_TRIAL,
        S_DECIDE,
        S_HAND
    } t_state;

    t_state             r_state, n_state;
    logic [LPW-1:0]     r_pos, n_pos;
    logic [DIGITS-1:0][DW-1:0] r_a, n_a;
    t_wvec              r_d, n_d;
    t_wvec              r_r, n_r;
    t_wvec              r_t, n_t;
    t_qvec              r_q, n_q;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [PW-1:0]      r_qpos, n_qpos;
    t_digit             r_qd, n_qd;
    logic               r_nz, n_nz;
    t_flags             r_flags, n_flags;

    t_digit             a_in, b_in, qd_new, sub_diff;
    logic               is_last, nz_next, sub_clear, sub_step, sub_borrow;

    // serial digit subtractor, remainder minus divisor, low digit first
    bfpd_digit_sub u_sub (
        .i_clk        (i_clk),
        .i_clear      (sub_clear),
        .i_step       (sub_step),
        .i_minuend    (r_r[0]),
        .i_subtrahend (r_d[0]),
        .o_diff       (sub_diff),
        .o_borrow     (sub_borrow)
    );

    // input decode
    always_comb begin
        a_in    = clamp_bcd(i_dividend_digit);
        b_in    = clamp_bcd(i_divisor_digit);
        is_last = i_last_digit || (r_pos == LPW'(DIGITS - 1));
        nz_next = ((r_pos == '0) ? 1'b0 : r_nz) | (b_in != ZERO_DIGIT);
        qd_new  = r_qd + {3'b000, ~sub_borrow};
    end

    // load, then one quotient position at a time from the top
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_a         = r_a;
        n_d         = r_d;
        n_r         = r_r;
        n_t         = r_t;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_qpos      = r_qpos;
        n_qd        = r_qd;
        n_nz        = r_nz;
        n_flags     = r_flags;
        sub_clear   = 1'b0;
        sub_step    = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_pos == '0) begin
                        n_a = '0;
                        n_d = '0;
                    end
                    for (int k = 0; k < DIGITS; k++) begin
                        if (r_pos == LPW'(k)) begin
                            n_a[k] = a_in;
                            n_d[k] = b_in;
                        end
                    end
                    n_nz = nz_next;
                    if (is_last) begin
                        n_pos            = '0;
                        n_flags.positive = ~(i_dividend_positive ^ i_divisor_positive);
                        n_flags.div_zero = ~nz_next;
                        n_flags.overflow = 1'b0;
                        n_q              = '0;
                        n_r              = '0;
                        n_qpos           = PW'(NPOS - 1);
                        n_state          = nz_next ? S_SHIFT : S_HAND;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            // bring down the next dividend digit
            S_SHIFT: begin
                n_r       = {r_r[WIN-2:0], r_a[DIGITS-1]};
                n_a       = {r_a[DIGITS-2:0], ZERO_DIGIT};
                n_qd      = ZERO_DIGIT;
                n_cnt     = '0;
                sub_clear = 1'b1;
                n_state   = S_TRIAL;
            end
            // trial subtract, remainder and divisor rotate back into place
            S_TRIAL: begin
                sub_step = 1'b1;
                n_t      = {sub_diff, r_t[WIN-1:1]};
                n_r      = {r_r[0], r_r[WIN-1:1]};
                n_d      = {r_d[0], r_d[WIN-1:1]};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CW'(WIN - 1)) begin
                    n_state = S_DECIDE;
                end
            end
            // keep the difference when no borrow came out of the top
            S_DECIDE: begin
                if (!sub_borrow) begin
                    n_r = r_t;
                end
                n_qd = qd_new;
                if (sub_borrow || (qd_new == BCD_MAX)) begin
                    n_q = {r_q[DIGITS-2:0], qd_new};
                    if ((r_qpos >= PW'(DIGITS)) && (qd_new != ZERO_DIGIT)) begin
                        n_flags.overflow = 1'b1;
                    end
                    if (r_qpos == '0) begin
                        n_state = S_HAND;
                    end else begin
                        n_qpos  = r_qpos - 1'b1;
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_cnt     = '0;
                    sub_clear = 1'b1;
                    n_state   = S_TRIAL;
                end
            end
            S_HAND: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_d     <= n_d;
        r_r     <= n_r;
        r_t     <= n_t;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_qpos  <= n_qpos;
        r_qd    <= n_qd;
        r_nz    <= n_nz;
        r_flags <= n_flags;
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    assign o_stall    = (r_state != S_LOAD);
    assign o_quotient = r_q;
    assign o_flags    = r_flags;

endmodule

### hdl/bcd_fixed_point_divider.sv
// Signed BCD fixed-point divider. Load the dividend and divisor one digit pair per item,
// least significant digit first; the item with last_digit set (or the item at position
// DIGITS-1) carries both signs and starts the division, and positions not loaded read
// as zero. The quotient is floor(dividend * 10^FRAC / divisor), returned as DIGITS
// items, least significant digit first, with last_result on the top digit; digits
// that fall above DIGITS set quotient_overflow, and a zero divisor gives all zero
// digits with divide_by_zero set. Items are accepted while the divider is idle. The
// division then runs one quotient position at a time through a single digit-serial
// BCD subtractor: each of the DIGITS+FRAC positions brings a dividend digit down and
// then makes min(q+1, 9) trial subtractions over the DIGITS+1 digit window, where q
// is that quotient digit; a zero divisor skips the division. The quotient moves into
// the output register once that register is empty and drains one item per cycle
// whenever i_stall is low, as the next operands load.
module bcd_fixed_point_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bfpd_pkg::t_digit    i_dividend_digit,
    input  bfpd_pkg::t_digit    i_divisor_digit,
    input  logic                i_dividend_positive,
    input  logic                i_divisor_positive,
    input  logic                i_last_digit,
    output logic                o_valid,
    input  logic                i_stall,
    output bfpd_pkg::t_digit    o_quotient_digit,
    output logic                o_quotient_positive,
    output logic                o_divide_by_zero,
    output logic                o_quotient_overflow,
    output logic                o_last_result
);
    import bfpd_pkg::*;

    logic           core_valid;
    t_qvec          core_quotient;
    t_flags         core_flags;
    logic           take;

    logic           r_valid, n_valid;
    logic [LPW-1:0] r_cnt, n_cnt;
    t_qvec          r_q, n_q;
    t_flags         r_flags, n_flags;

    bfpd_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_dividend_digit    (i_dividend_digit),
        .i_divisor_digit     (i_divisor_digit),
        .i_dividend_positive (i_dividend_positive),
        .i_divisor_positive  (i_divisor_positive),
        .i_last_digit        (i_last_digit),
        .o_res_valid         (core_valid),
        .i_res_take          (take),
        .o_quotient          (core_quotient),
        .o_flags             (core_flags)
    );

    assign take = ~r_valid;

    // output shift register, low digit first
    always_comb begin
        n_valid = r_valid;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_flags = r_flags;
        if (!r_valid) begin
            if (core_valid) begin
                n_valid = 1'b1;
                n_cnt   = '0;
                n_q     = core_quotient;
                n_flags = core_flags;
            end
        end else if (!i_stall) begin
            n_q   = {ZERO_DIGIT, r_q[DIGITS-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LPW'(DIGITS - 1)) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q     <= n_q;
        r_flags <= n_flags;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    assign o_valid             = r_valid;
    assign o_quotient_digit    = r_q[0];
    assign o_quotient_positive = r_flags.positive;
    assign o_divide_by_zero    = r_flags.div_zero;
    assign o_quotient_overflow = r_flags.overflow;
    assign o_last_result       = (r_cnt == LPW'(DIGITS - 1));

endmodule

### hdl/bfpd_checker.sv
module bfpd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_valid,
    input  logic                i_stall,
    input  bfpd_pkg::t_digit    o_quotient_digit,
    input  logic                o_quotient_positive,
    input  logic                o_divide_by_zero,
    input  logic                o_quotient_overflow,
    input  logic                o_last_result
);
    import bfpd_pkg::*;

    // a stalled item holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_quotient_digit) && $stable(o_last_result)))
        else $error("stalled output item changed");

    // one quotient keeps its flags from first to last digit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_result) |=>
            (o_valid && $stable(o_quotient_positive) && $stable(o_divide_by_zero)
             && $stable(o_quotient_overflow)))
        else $error("quotient flags changed inside one quotient");

    // zero divisor gives zero digits and no overflow
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |->
            ((o_quotient_digit == ZERO_DIGIT) && !o_quotient_overflow))
        else $error("divide by zero with nonzero quotient or overflow");

    // quotient digits stay decimal
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quotient_digit <= BCD_MAX))
        else $error("quotient digit is not bcd");

endmodule

bind bcd_fixed_point_divider bfpd_checker u_bfpd_checker (.*);

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bfpd_pkg::*;

    localparam int REM_LEN    = DIGITS + FRAC + 1;
    localparam int DEC_BASE   = 10;
    localparam int HOLDOFF    = 15000;
    localparam int IDLE_LIMIT = 60000;
    localparam int TAIL       = 50;
    localparam int RAND_ITEMS = 280;

    // how operand digits are drawn
    typedef enum int {
        DK_RANDOM,
        DK_RAW,
        DK_ZERO,
        DK_NINE,
        DK_ONE,
        DK_LOW
    } t_digit_kind;

    typedef struct packed {
        t_digit dividend_digit;
        t_digit divisor_digit;
        logic   dividend_positive;
        logic   divisor_positive;
        logic   last_digit;
    } t_digit_pair;

    typedef struct packed {
        t_digit digit;
        logic   positive;
        logic   div_zero;
        logic   overflow;
        logic   last;
    } t_quotient_item;

    // block ports
    logic   i_clk               = 1'b0;
    logic   i_rst_n             = 1'b0;
    logic   i_valid             = 1'b0;
    logic   o_stall;
    t_digit i_dividend_digit    = '0;
    t_digit i_divisor_digit     = '0;
    logic   i_dividend_positive = 1'b1;
    logic   i_divisor_positive  = 1'b1;
    logic   i_last_digit        = 1'b0;
    logic   o_valid;
    logic   i_stall             = 1'b0;
    t_digit o_quotient_digit;
    logic   o_quotient_positive;
    logic   o_divide_by_zero;
    logic   o_quotient_overflow;
    logic   o_last_result;

    bcd_fixed_point_divider DUT (.*);

    always #5 i_clk = ~i_clk;

    // stimulus and expectations
    t_digit_pair    digit_pairs[$];
    t_quotient_item quotient_due[$];

    // divider state as seen by the predictor
    t_digit      scaled_rem [REM_LEN];
    t_digit      div_reg    [DIGITS + 1];
    t_digit      quo_digits [DIGITS];
    int unsigned load_pos;
    logic        zero_seen;
    logic        ovf_seen;

    // run bookkeeping
    int  total_items;
    int  cnt_accepted;
    int  cnt_checked;
    int  cnt_errors;
    int  cnt_divisions;
    int  cnt_by_zero;
    int  cnt_overflow;
    int  idle_cycles;
    bit  in_taken;
    bit  offering;
    bit  snd_quiet;
    int  snd_gap;
    bit  rcv_quiet;
    int  rcv_wait;
    bit  holdoff_due;
    bit  holdoff_used;
    t_digit_pair    next_pair;
    t_quotient_item want;

    function automatic void clear_operands();
        foreach (scaled_rem[i]) scaled_rem[i] = ZERO_DIGIT;
        foreach (div_reg[i]) div_reg[i] = ZERO_DIGIT;
        load_pos = 0;
    endfunction

    // restoring long division on the loaded operands
    function automatic void run_division();
        int top_a, top_b, span, n, borrow, diff;
        bit less, decided;
        foreach (quo_digits[i]) quo_digits[i] = ZERO_DIGIT;
        zero_seen = 1'b0;
        ovf_seen  = 1'b0;
        top_a = -1;
        top_b = -1;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            if (top_a < 0 && scaled_rem[FRAC + i] != ZERO_DIGIT) top_a = i;
            if (top_b < 0 && div_reg[i] != ZERO_DIGIT) top_b = i;
        end
        if (top_b < 0) begin
            zero_seen = 1'b1;
            return;
        end
        if (top_a < 0) top_a = 0;
        top_a += FRAC;
        if (top_b > top_a) return;
        span = top_a - top_b;
        for (int p = span; p >= 0; p--) begin
            n    = 0;
            less = 1'b0;
            while (n < int'(BCD_MAX) && !less) begin
                // compare the window from the top digit down
                decided = 1'b0;
                for (int j = top_b + 1; j >= 0; j--) begin
                    if (!decided && scaled_rem[j + p] != div_reg[j]) begin
                        decided = 1'b1;
                        less    = scaled_rem[j + p] < div_reg[j];
                    end
                end
                // subtract the divisor with decimal borrow
                if (!less) begin
                    borrow = 0;
                    for (int j = 0; j <= top_b + 1; j++) begin
                        diff   = int'(scaled_rem[j + p]) - int'(div_reg[j]) - borrow;
                        borrow = (diff < 0) ? 1 : 0;
                        scaled_rem[j + p] = t_digit'(diff + DEC_BASE * borrow);
                    end
                    n++;
                end
            end
            if (p < DIGITS) quo_digits[p] = t_digit'(n);
            else if (n != 0) ovf_seen = 1'b1;
        end
    endfunction

    // load one digit pair, divide when the operands are complete
    function automatic void take_digit_pair(input t_digit_pair pair);
        t_digit a, b;
        logic   positive;
        int     pos;
        t_quotient_item q;
        a   = (pair.dividend_digit > BCD_MAX) ? BCD_MAX : pair.dividend_digit;
        b   = (pair.divisor_digit > BCD_MAX) ? BCD_MAX : pair.divisor_digit;
        pos = load_pos;
        scaled_rem[FRAC + pos] = a;
        div_reg[pos]           = b;
        if (!pair.last_digit && pos != DIGITS - 1) begin
            load_pos = pos + 1;
            return;
        end
        positive = ~(pair.dividend_positive ^ pair.divisor_positive);
        run_division();
        cnt_divisions++;
        if (zero_seen) cnt_by_zero++;
        if (ovf_seen) cnt_overflow++;
        for (int k = 0; k < DIGITS; k++) begin
            q.digit    = quo_digits[k];
            q.positive = positive;
            q.div_zero = zero_seen;
            q.overflow = ovf_seen;
            q.last     = (k == DIGITS - 1);
            quotient_due.push_back(q);
        end
        clear_operands();
    endfunction

    function automatic t_digit pick_digit(input t_digit_kind kind, input int pos);
        case (kind)
            DK_RAW:  return t_digit'($urandom_range(0, 15));
            DK_ZERO: return ZERO_DIGIT;
            DK_NINE: return BCD_MAX;
            DK_ONE:  return (pos == 0) ? t_digit'(1) : ZERO_DIGIT;
            DK_LOW:  return (pos < 2) ? t_digit'($urandom_range(0, 9)) : ZERO_DIGIT;
            default: return t_digit'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic t_digit_kind pick_kind(input bit for_divisor);
        int r;
        r = $urandom_range(0, 19);
        if (r <= 10) return DK_RANDOM;
        if (r <= 12) return DK_RAW;
        if (r <= 14) return DK_NINE;
        if (r <= 16) return DK_LOW;
        if (r == 17) return DK_ONE;
        if (r == 18 || !for_divisor) return DK_ZERO;
        return DK_RANDOM;
    endfunction

    // one operand set, least significant pair first; signs ride on the top pair
    task automatic queue_operands(input int len, input bit mark_last,
                                  input t_digit_kind ka, input t_digit_kind kb,
                                  input logic sa, input logic sb);
        t_digit_pair pair;
        bit          is_top;
        for (int p = 0; p < len; p++) begin
            is_top                 = (p == len - 1);
            pair.dividend_digit    = pick_digit(ka, p);
            pair.divisor_digit     = pick_digit(kb, p);
            pair.last_digit        = is_top ? mark_last : 1'b0;
            pair.dividend_positive = is_top ? sa : logic'($urandom_range(0, 1));
            pair.divisor_positive  = is_top ? sb : logic'($urandom_range(0, 1));
            digit_pairs.push_back(pair);
        end
    endtask

    // sender: offers queued items at the falling edge
    always @(negedge i_clk) begin
        if (in_taken) begin
            in_taken = 1'b0;
            offering = 1'b0;
            if ($urandom_range(0, 24) == 0) snd_quiet = !snd_quiet;
            snd_gap = snd_quiet ? 0 : $urandom_range(0, 9);
        end
        if (!offering && i_rst_n) begin
            if (snd_gap > 0) begin
                snd_gap--;
            end else if (digit_pairs.size() > 0) begin
                next_pair = digit_pairs.pop_front();
                offering  = 1'b1;
                i_dividend_digit    <= next_pair.dividend_digit;
                i_divisor_digit     <= next_pair.divisor_digit;
                i_dividend_positive <= next_pair.dividend_positive;
                i_divisor_positive  <= next_pair.divisor_positive;
                i_last_digit        <= next_pair.last_digit;
            end
        end
        i_valid <= offering;
    end

    // receiver: random stall per result, one long hold-off
    always @(negedge i_clk) begin
        if (holdoff_due) begin
            holdoff_due  = 1'b0;
            holdoff_used = 1'b1;
            rcv_wait     = HOLDOFF;
        end
        if (rcv_wait > 0) begin
            i_stall <= 1'b1;
            rcv_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (i_valid && !o_stall) begin
                take_digit_pair({i_dividend_digit, i_divisor_digit, i_dividend_positive,
                                 i_divisor_positive, i_last_digit});
                cnt_accepted++;
                in_taken    = 1'b1;
                idle_cycles = 0;
            end
            if (o_valid && !i_stall) begin
                idle_cycles = 0;
                if (quotient_due.size() == 0) begin
                    $error("quotient digit %0d with no division pending", o_quotient_digit);
                    cnt_errors++;
                end else begin
                    want = quotient_due.pop_front();
                    if (o_quotient_digit !== want.digit) begin
                        $error("quotient_digit: expected %0d, got %0d",
                               want.digit, o_quotient_digit);
                        cnt_errors++;
                    end
                    if (o_quotient_positive !== want.positive) begin
                        $error("quotient_positive: expected %0b, got %0b",
                               want.positive, o_quotient_positive);
                        cnt_errors++;
                    end
                    if (o_divide_by_zero !== want.div_zero) begin
                        $error("divide_by_zero: expected %0b, got %0b",
                               want.div_zero, o_divide_by_zero);
                        cnt_errors++;
                    end
                    if (o_quotient_overflow !== want.overflow) begin
                        $error("quotient_overflow: expected %0b, got %0b",
                               want.overflow, o_quotient_overflow);
                        cnt_errors++;
                    end
                    if (o_last_result !== want.last) begin
                        $error("last_result: expected %0b, got %0b",
                               want.last, o_last_result);
                        cnt_errors++;
                    end
                end
                cnt_checked++;
                if ($urandom_range(0, 19) == 0) rcv_quiet = !rcv_quiet;
                rcv_wait = rcv_quiet ? 0 : $urandom_range(0, 9);
                if (cnt_checked == 200 && !holdoff_used) holdoff_due = 1'b1;
            end
            // watchdog on cycles with no handshake at all
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d cycles with no item moving", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        clear_operands();

        // directed: extremes, signs, non-bcd codes and the special cases
        queue_operands(1, 1'b1, DK_NINE, DK_ONE, 1'b1, 1'b1);
        queue_operands(1, 1'b1, DK_RANDOM, DK_ZERO, 1'b0, 1'b1);
        queue_operands(2, 1'b1, DK_ZERO, DK_NINE, 1'b1, 1'b0);
        queue_operands(1, 1'b1, DK_RAW, DK_RAW, 1'b0, 1'b0);
        queue_operands(3, 1'b1, DK_NINE, DK_NINE, 1'b1, 1'b1);
        // divisor wider than the scaled dividend gives a zero quotient
        queue_operands(12, 1'b1, DK_ONE, DK_NINE, 1'b0, 1'b1);
        // full width without last_digit: ends at the top position, overflows
        queue_operands(DIGITS, 1'b0, DK_NINE, DK_ONE, 1'b1, 1'b0);

        // random: mostly short operands, now and then full width
        while (digit_pairs.size() < RAND_ITEMS) begin
            int sel, len;
            sel = $urandom_range(0, 19);
            if (sel == 0) len = DIGITS;
            else if (sel < 4) len = $urandom_range(7, 20);
            else len = $urandom_range(1, 6);
            queue_operands(len, (len < DIGITS) || ($urandom_range(0, 1) == 1),
                           pick_kind(1'b0), pick_kind(1'b1),
                           logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
        end
        total_items = digit_pairs.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cnt_accepted < total_items || quotient_due.size() > 0) @(negedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        $display("%0d items in %0d divisions (%0d by zero, %0d overflowed)",
                 cnt_accepted, cnt_divisions, cnt_by_zero, cnt_overflow);
        $display("%0d quotient digits checked, receiver hold-off of %0d cycles applied",
                 cnt_checked, HOLDOFF);
        if (cnt_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
